/* rtl/pps_pkg.sv */
package pps_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 136;

  typedef enum logic [STAT_W-1:0] {
    ST_ADMITTED   = 3'd0,
    ST_FULL       = 3'd1,
    ST_ZERO_BURST = 3'd2,
    ST_RAN        = 3'd3,
    ST_FINISHED   = 3'd4,
    ST_IDLE       = 3'd5
  } status_e;

  typedef enum logic {
    FUNC_ADMIT = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef struct packed {
    logic admit;
    logic run;
    logic retire;
  } tbl_cmd_t;

endpackage

/* rtl/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler. Each input transaction is either an admit
// (tuser 0) that files a task with a nonzero burst into the lowest free
// table slot, if any, or a tick (tuser 1) that runs one time unit of the
// ready task with the smallest priority value (ties: oldest arrival, then
// lowest slot), if any, and advances time. Every input transaction yields
// exactly one output transaction. Throughput is one transaction per cycle
// unless the output stalls; input and result registers surround a compare
// tree over all slots, whose log2(TABLE_DEPTH) levels bound the clock rate.
module preemptive_priority_scheduler #(
  parameter int unsigned TABLE_DEPTH = pps_pkg::DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // task_id[7:0], burst_length[23:8], priority_level[31:24]
  input  logic [pps_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // func[0]
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // served_id[7:0], finish_time[39:8], turnaround[71:40], waiting[103:72],
  // now[135:104]
  output logic [pps_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // status[2:0]
  output logic [pps_pkg::STAT_W-1:0]         m_axis_tuser_o
);
  import pps_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  logic               in_vld_q;
  func_e              func_q;
  logic [ID_W-1:0]    id_q;
  logic [BURST_W-1:0] burst_q;
  logic [PRIO_W-1:0]  prio_q;
  logic [TIME_W-1:0]  now_q, now_d;

  logic               out_vld_q;
  status_e            status_q, status_d;
  logic [ID_W-1:0]    served_q, served_d;
  logic [TIME_W-1:0]  fin_q, fin_d;
  logic [TIME_W-1:0]  tat_q, tat_d;
  logic [TIME_W-1:0]  wt_q, wt_d;

  logic               fire;
  tbl_cmd_t           cmd;

  logic [TABLE_DEPTH-1:0] tbl_valid;
  logic [PRIO_W-1:0]      tbl_prio    [TABLE_DEPTH];
  logic [TIME_W-1:0]      tbl_arrival [TABLE_DEPTH];
  logic [ID_W-1:0]        run_task;
  logic [TIME_W-1:0]      run_arrival;
  logic [BURST_W-1:0]     run_remain;
  logic [BURST_W-1:0]     run_orig;
  logic                   found;
  logic [IdxW-1:0]        win_idx;
  logic                   free;
  logic [IdxW-1:0]        free_idx;
  logic [TIME_W-1:0]      now_inc;

  assign fire            = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      now_q     <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
        now_q     <= now_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      func_q  <= func_e'(s_axis_tuser_i);
      id_q    <= s_axis_tdata_i[7:0];
      burst_q <= s_axis_tdata_i[23:8];
      prio_q  <= s_axis_tdata_i[31:24];
    end
    if (fire) begin
      status_q <= status_d;
      served_q <= served_d;
      fin_q    <= fin_d;
      tat_q    <= tat_d;
      wt_q     <= wt_d;
    end
  end

  pps_slot_table #(
    .TableDepth(TABLE_DEPTH)
  ) u_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .admit_idx_i    (free_idx),
    .run_idx_i      (win_idx),
    .admit_task_i   (id_q),
    .admit_arrival_i(now_q),
    .admit_burst_i  (burst_q),
    .admit_prio_i   (prio_q),
    .valid_o        (tbl_valid),
    .prio_o         (tbl_prio),
    .arrival_o      (tbl_arrival),
    .run_task_o     (run_task),
    .run_arrival_o  (run_arrival),
    .run_remain_o   (run_remain),
    .run_orig_o     (run_orig)
  );

  pps_pick #(
    .TableDepth(TABLE_DEPTH)
  ) u_pick (
    .valid_i   (tbl_valid),
    .prio_i    (tbl_prio),
    .arrival_i (tbl_arrival),
    .now_i     (now_q),
    .found_o   (found),
    .win_idx_o (win_idx),
    .free_o    (free),
    .free_idx_o(free_idx)
  );

  assign now_inc = now_q + TIME_W'(1);

  always_comb begin
    cmd      = '0;
    status_d = ST_IDLE;
    served_d = '0;
    fin_d    = '0;
    tat_d    = '0;
    wt_d     = '0;
    now_d    = now_q;
    case (func_q)
      FUNC_ADMIT: begin
        if (burst_q == '0) begin
          status_d = ST_ZERO_BURST;
        end else if (!free) begin
          status_d = ST_FULL;
        end else begin
          status_d  = ST_ADMITTED;
          served_d  = id_q;
          cmd.admit = fire;
        end
      end
      FUNC_TICK: begin
        now_d = now_inc;
        if (found) begin
          served_d = run_task;
          cmd.run  = fire;
          if (run_remain <= BURST_W'(1)) begin
            status_d   = ST_FINISHED;
            cmd.retire = fire;
            fin_d      = now_inc;
            tat_d      = now_inc - run_arrival;
            wt_d       = now_inc - run_arrival - TIME_W'(run_orig);
          end else begin
            status_d = ST_RAN;
          end
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {now_q, wt_q, tat_q, fin_q, served_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (func_q == FUNC_TICK) |=> now_q == $past(now_q) + TIME_W'(1))
    else $error("tick did not advance time");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (func_q == FUNC_ADMIT) |=> $stable(now_q))
    else $error("admit moved time");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.admit |=> $countones(tbl_valid) == $countones($past(tbl_valid)) + 1)
    else $error("admit did not fill exactly one slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (status_d == ST_FULL) |-> &tbl_valid)
    else $error("table reported full with a free slot");

endmodule

/* rtl/pps_slot_table.sv */
module pps_slot_table #(
  parameter int unsigned TableDepth = pps_pkg::DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pps_pkg::tbl_cmd_t                 cmd_i,
  input  logic [$clog2(TableDepth)-1:0]     admit_idx_i,
  input  logic [$clog2(TableDepth)-1:0]     run_idx_i,
  input  logic [pps_pkg::ID_W-1:0]          admit_task_i,
  input  logic [pps_pkg::TIME_W-1:0]        admit_arrival_i,
  input  logic [pps_pkg::BURST_W-1:0]       admit_burst_i,
  input  logic [pps_pkg::PRIO_W-1:0]        admit_prio_i,
  output logic [TableDepth-1:0]             valid_o,
  output logic [pps_pkg::PRIO_W-1:0]        prio_o    [TableDepth],
  output logic [pps_pkg::TIME_W-1:0]        arrival_o [TableDepth],
  output logic [pps_pkg::ID_W-1:0]          run_task_o,
  output logic [pps_pkg::TIME_W-1:0]        run_arrival_o,
  output logic [pps_pkg::BURST_W-1:0]       run_remain_o,
  output logic [pps_pkg::BURST_W-1:0]       run_orig_o
);
  import pps_pkg::*;

  logic [TableDepth-1:0] valid_q;
  logic [ID_W-1:0]       task_q    [TableDepth];
  logic [TIME_W-1:0]     arrival_q [TableDepth];
  logic [BURST_W-1:0]    remain_q  [TableDepth];
  logic [BURST_W-1:0]    orig_q    [TableDepth];
  logic [PRIO_W-1:0]     prio_q    [TableDepth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.admit) begin
        valid_q[admit_idx_i] <= 1'b1;
      end
      if (cmd_i.retire) begin
        valid_q[run_idx_i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.admit) begin
      task_q[admit_idx_i]    <= admit_task_i;
      arrival_q[admit_idx_i] <= admit_arrival_i;
      remain_q[admit_idx_i]  <= admit_burst_i;
      orig_q[admit_idx_i]    <= admit_burst_i;
      prio_q[admit_idx_i]    <= admit_prio_i;
    end else if (cmd_i.run) begin
      remain_q[run_idx_i] <= remain_q[run_idx_i] - BURST_W'(1);
    end
  end

  assign valid_o       = valid_q;
  assign prio_o        = prio_q;
  assign arrival_o     = arrival_q;
  assign run_task_o    = task_q[run_idx_i];
  assign run_arrival_o = arrival_q[run_idx_i];
  assign run_remain_o  = remain_q[run_idx_i];
  assign run_orig_o    = orig_q[run_idx_i];

endmodule

/* rtl/pps_pick.sv */
module pps_pick #(
  parameter int unsigned TableDepth = pps_pkg::DEPTH
) (
  input  logic [TableDepth-1:0]          valid_i,
  input  logic [pps_pkg::PRIO_W-1:0]     prio_i    [TableDepth],
  input  logic [pps_pkg::TIME_W-1:0]     arrival_i [TableDepth],
  input  logic [pps_pkg::TIME_W-1:0]     now_i,
  output logic                           found_o,
  output logic [$clog2(TableDepth)-1:0]  win_idx_o,
  output logic                           free_o,
  output logic [$clog2(TableDepth)-1:0]  free_idx_o
);
  import pps_pkg::*;

  localparam int unsigned IdxW   = $clog2(TableDepth);
  localparam int unsigned Leaves = 1 << IdxW;

  // heap-ordered compare tree, node 1 is the root, leaves start at Leaves
  logic              node_vld  [2*Leaves];
  logic [PRIO_W-1:0] node_prio [2*Leaves];
  logic [TIME_W-1:0] node_age  [2*Leaves];
  logic [IdxW-1:0]   node_idx  [2*Leaves];

  always_comb begin
    logic take_r;
    node_vld[0]  = 1'b0;
    node_prio[0] = '0;
    node_age[0]  = '0;
    node_idx[0]  = '0;
    for (int i = 0; i < Leaves; i++) begin
      if (i < TableDepth) begin
        node_vld[Leaves+i]  = valid_i[i];
        node_prio[Leaves+i] = prio_i[i];
        node_age[Leaves+i]  = now_i - arrival_i[i];
      end else begin
        node_vld[Leaves+i]  = 1'b0;
        node_prio[Leaves+i] = '0;
        node_age[Leaves+i]  = '0;
      end
      node_idx[Leaves+i] = IdxW'(i);
    end
    for (int n = Leaves - 1; n >= 1; n--) begin
      // right child holds higher slots: it wins only when strictly better
      take_r = node_vld[2*n+1] &&
               (!node_vld[2*n] ||
                (node_prio[2*n+1] < node_prio[2*n]) ||
                ((node_prio[2*n+1] == node_prio[2*n]) &&
                 (node_age[2*n+1] > node_age[2*n])));
      node_vld[n]  = node_vld[2*n] | node_vld[2*n+1];
      node_prio[n] = take_r ? node_prio[2*n+1] : node_prio[2*n];
      node_age[n]  = take_r ? node_age[2*n+1]  : node_age[2*n];
      node_idx[n]  = take_r ? node_idx[2*n+1]  : node_idx[2*n];
    end
  end

  assign found_o   = node_vld[1];
  assign win_idx_o = node_idx[1];

  always_comb begin
    free_idx_o = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!valid_i[i]) begin
        free_idx_o = IdxW'(i);
      end
    end
  end

  assign free_o = ~&valid_i;

endmodule

/* test/pps_sched_checker.sv */
`timescale 1ns / 1ps

module pps_sched_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  // task_id[7:0], burst_length[23:8], priority_level[31:24]
  input  logic [pps_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // func[0]
  input  logic                           s_axis_tuser_i,
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  // served_id[7:0], finish_time[39:8], turnaround[71:40], waiting[103:72],
  // now[135:104]
  input  logic [pps_pkg::OUT_DATA_W-1:0] m_axis_tdata_i,
  // status[2:0]
  input  logic [pps_pkg::STAT_W-1:0]     m_axis_tuser_i,
  output int                             mismatch_count_o,
  output int                             pending_o
);
  import pps_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    served_id;
    logic [TIME_W-1:0]  finish_time;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic [TIME_W-1:0]  now;
  } sched_outcome_t;

  logic                tbl_valid   [DEPTH];
  logic [ID_W-1:0]     tbl_id      [DEPTH];
  logic [TIME_W-1:0]   tbl_arrival [DEPTH];
  logic [BURST_W-1:0]  tbl_left    [DEPTH];
  logic [BURST_W-1:0]  tbl_burst   [DEPTH];
  logic [PRIO_W-1:0]   tbl_prio    [DEPTH];
  logic [TIME_W-1:0]   sched_clock;

  sched_outcome_t pending_outcomes[$];
  sched_outcome_t want;
  sched_outcome_t got;

  task automatic schedule_step(input func_e op, input logic [ID_W-1:0] id,
                               input logic [BURST_W-1:0] burst,
                               input logic [PRIO_W-1:0] prio,
                               output sched_outcome_t res);
    int slot;
    logic [TIME_W-1:0] age_i;
    logic [TIME_W-1:0] age_b;
    res = '0;
    slot = -1;
    if (op == FUNC_ADMIT) begin
      if (burst == '0) begin
        res.status = ST_ZERO_BURST;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!tbl_valid[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          res.status = ST_FULL;
        end else begin
          tbl_valid[slot]   = 1'b1;
          tbl_id[slot]      = id;
          tbl_arrival[slot] = sched_clock;
          tbl_left[slot]    = burst;
          tbl_burst[slot]   = burst;
          tbl_prio[slot]    = prio;
          res.status        = ST_ADMITTED;
          res.served_id     = id;
        end
      end
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_valid[i]) begin
          if (slot < 0) begin
            slot = i;
          end else if (tbl_prio[i] < tbl_prio[slot]) begin
            slot = i;
          end else if (tbl_prio[i] == tbl_prio[slot]) begin
            // oldest wins, age taken modulo 2^32
            age_i = sched_clock - tbl_arrival[i];
            age_b = sched_clock - tbl_arrival[slot];
            if (age_i > age_b) slot = i;
          end
        end
      end
      sched_clock = sched_clock + 1;
      if (slot < 0) begin
        res.status = ST_IDLE;
      end else begin
        res.served_id = tbl_id[slot];
        if (tbl_left[slot] <= 1) begin
          tbl_left[slot]  = '0;
          tbl_valid[slot] = 1'b0;
          res.finish_time = sched_clock;
          res.turnaround  = sched_clock - tbl_arrival[slot];
          res.waiting     = res.turnaround - TIME_W'(tbl_burst[slot]);
          res.status      = ST_FINISHED;
        end else begin
          tbl_left[slot] = tbl_left[slot] - 1'b1;
          res.status     = ST_RAN;
        end
      end
    end
    res.now = sched_clock;
  endtask

  task automatic check_field(input string what, input logic [TIME_W-1:0] want_v,
                             input logic [TIME_W-1:0] got_v);
    if (want_v !== got_v) begin
      if (mismatch_count_o < 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
      end
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
      sched_clock = '0;
      pending_outcomes.delete();
      mismatch_count_o = 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status      = status_e'(m_axis_tuser_i);
        got.served_id   = m_axis_tdata_i[7:0];
        got.finish_time = m_axis_tdata_i[39:8];
        got.turnaround  = m_axis_tdata_i[71:40];
        got.waiting     = m_axis_tdata_i[103:72];
        got.now         = m_axis_tdata_i[135:104];
        if (pending_outcomes.size() == 0) begin
          if (mismatch_count_o < 10) begin
            $display("%0t: result transaction with none outstanding, status %0d id %0d",
                     $time, got.status, got.served_id);
          end
          mismatch_count_o++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("status", TIME_W'(want.status), TIME_W'(got.status));
          check_field("served_id", TIME_W'(want.served_id), TIME_W'(got.served_id));
          check_field("finish_time", want.finish_time, got.finish_time);
          check_field("turnaround", want.turnaround, got.turnaround);
          check_field("waiting", want.waiting, got.waiting);
          check_field("now", want.now, got.now);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        schedule_step(func_e'(s_axis_tuser_i), s_axis_tdata_i[7:0],
                      s_axis_tdata_i[23:8], s_axis_tdata_i[31:24], want);
        pending_outcomes.push_back(want);
      end
      pending_o <= pending_outcomes.size();
    end
  end

endmodule

/* test/tb_preemptive_priority_scheduler.sv */
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler;
  import pps_pkg::*;

  localparam int STALL_LIMIT     = 1000;
  localparam int ITEMS_PER_PHASE = 350;
  localparam int IDLE_PLAN[4]    = '{0, 47, 0, 28};
  localparam int STALL_PLAN[4]   = '{0, 0, 47, 28};

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  s_valid = 1'b0;
  logic [IN_DATA_W-1:0]  s_data  = '0;
  logic                  s_user  = 1'b0;
  logic                  s_ready;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic [STAT_W-1:0]     m_user;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int mismatches;
  int outstanding;

  always #2 clk = ~clk;

  preemptive_priority_scheduler u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  pps_sched_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_valid),
    .s_axis_tready_i  (s_ready),
    .s_axis_tdata_i   (s_data),
    .s_axis_tuser_i   (s_user),
    .m_axis_tvalid_i  (m_valid),
    .m_axis_tready_i  (m_ready),
    .m_axis_tdata_i   (m_data),
    .m_axis_tuser_i   (m_user),
    .mismatch_count_o (mismatches),
    .pending_o        (outstanding)
  );

  always @(posedge clk) begin
    m_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // valid stays high across back-to-back transactions, dropped only for gaps
  task automatic send_item(input func_e op, input logic [ID_W-1:0] id,
                           input logic [BURST_W-1:0] burst,
                           input logic [PRIO_W-1:0] prio);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {prio, burst, id};
    do @(posedge clk); while (!s_ready);
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    int                 tick_pct;
    int                 pick;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(FUNC_TICK, 8'h00, 16'h0000, 8'h00);   // empty table: idle
    send_item(FUNC_ADMIT, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(FUNC_ADMIT, 8'h00, 16'h0001, 8'h00);
    send_item(FUNC_TICK, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(FUNC_ADMIT, 8'hAA, 16'h0002, 8'h09);
    send_item(FUNC_TICK, 8'h00, 16'h0000, 8'h00);
    send_item(FUNC_ADMIT, 8'h55, 16'h0001, 8'h09);  // same priority, younger
    send_item(FUNC_TICK, 8'h00, 16'h0000, 8'h00);
    send_item(FUNC_TICK, 8'h00, 16'h0000, 8'h00);
    for (int i = 0; i < DEPTH - 1; i++) begin
      send_item(FUNC_ADMIT, 8'(8'h10 + i), 16'(1 + i % 3), 8'(i % 2));
    end
    send_item(FUNC_ADMIT, 8'h77, 16'h0005, 8'h01);  // table full
    send_item(FUNC_ADMIT, 8'h78, 16'h0000, 8'h01);  // zero burst beats full
    drain_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct = IDLE_PLAN[p];
      stall_pct <= STALL_PLAN[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // alternate fill-heavy and drain-heavy stretches
        tick_pct = ((n / 50) % 2) ? 75 : 30;
        if ($urandom_range(99) < tick_pct) begin
          send_item(FUNC_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
        end else begin
          pick = $urandom_range(199);
          prio = ($urandom_range(9) < 7) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
          if (pick < 6) begin
            burst = '0;
          end else if (pick == 6) begin
            burst = 16'($urandom_range(65535, 1024));
            prio  = 8'hFF;
          end else begin
            burst = 16'($urandom_range(4, 1));
          end
          send_item(FUNC_ADMIT, 8'($urandom), burst, prio);
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pps_pkg.sv
rtl/pps_slot_table.sv
rtl/pps_pick.sv
rtl/preemptive_priority_scheduler.sv
test/pps_sched_checker.sv
test/tb_preemptive_priority_scheduler.sv
